// ----- src/clip_rectangle_stack_macros.svh -----
// Assertion macros shared by the clip stack RTL.
// Each expects signals named clk and rst in the including module.
`ifndef CLIP_RECTANGLE_STACK_MACROS_SVH
`define CLIP_RECTANGLE_STACK_MACROS_SVH

// Condition must hold whenever the antecedent holds.
`define CRS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define CRS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/crs_pkg.sv -----
`default_nettype none

package crs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(STACK_DEPTH - 1);

  // Port widths
  localparam int CMD_W       = 3;
  localparam int IN_DATA_W   = 64;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = 160;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int SCALE_W     = 12;
  localparam int WIN_W       = 15;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUSH_CLIP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FULL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLIP_BOX  = 3'd4;

  // Region kinds
  localparam logic [1:0] KIND_FULL  = 2'd0;
  localparam logic [1:0] KIND_RECT  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Classify answers
  localparam logic [1:0] VIS_OUTSIDE = 2'd0;
  localparam logic [1:0] VIS_INSIDE  = 2'd1;
  localparam logic [1:0] VIS_PARTIAL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE         = 2'd2;

  localparam logic [WIN_W-1:0]   RST_WINDOW_WIDTH  = 15'd640;
  localparam logic [WIN_W-1:0]   RST_WINDOW_HEIGHT = 15'd480;
  localparam logic [SCALE_W-1:0] RST_SCALE         = 12'd256;

  // Scissor stack operations
  localparam logic [2:0] SC_NONE = 3'd0;
  localparam logic [2:0] SC_SET  = 3'd1;
  localparam logic [2:0] SC_COPY = 3'd2;
  localparam logic [2:0] SC_ZERO = 3'd3;
  localparam logic [2:0] SC_POP  = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } region_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] w;
    logic signed [19:0] h;
  } scissor_t;

  // Scissor stage command: operation and unscaled operands
  typedef struct packed {
    logic [2:0]         op;
    logic signed [19:0] opx;
    logic signed [19:0] opy;
    logic signed [19:0] opw;
    logic signed [19:0] oph;
  } sc_cmd_t;

endpackage

`default_nettype wire

// ----- src/crs_ram.sv -----
`default_nettype none

module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/crs_scissor.sv -----
`default_nettype none

`include "clip_rectangle_stack_macros.svh"

module crs_scissor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  crs_pkg::sc_cmd_t             cmd,
  input  logic [crs_pkg::SCALE_W-1:0]  scale,
  output crs_pkg::scissor_t            sc_out
);
  import crs_pkg::*;

  logic [LEVEL_W-1:0] level_b;
  logic [LEVEL_W-1:0] level_b_next;
  logic [LEVEL_W-1:0] rd_addr;
  scissor_t           top_sc;
  scissor_t           top_sc_next;
  scissor_t           below_sc;
  scissor_t           scaled;
  scissor_t           new_sc;
  logic               wr_en;
  logic signed [32:0] scale_s;
  logic signed [32:0] px;
  logic signed [32:0] py;
  logic signed [32:0] pw;
  logic signed [32:0] ph;

  // Divide by 256 truncating toward zero, then clamp to 20 bits.
  function automatic logic signed [19:0] q8_sat(input logic signed [32:0] p);
    logic signed [32:0] t;
    t = p + (p[32] ? 33'sd255 : 33'sd0);
    t = t >>> 8;
    if (t > 33'sd524287) begin
      return 20'sd524287;
    end else if (t < -33'sd524288) begin
      return -20'sd524288;
    end else begin
      return t[19:0];
    end
  endfunction

  assign scale_s = $signed({21'd0, scale});
  assign px = 33'(cmd.opx) * scale_s;
  assign py = 33'(cmd.opy) * scale_s;
  assign pw = 33'(cmd.opw) * scale_s;
  assign ph = 33'(cmd.oph) * scale_s;

  assign scaled.x = q8_sat(px);
  assign scaled.y = q8_sat(py);
  assign scaled.w = q8_sat(pw);
  assign scaled.h = q8_sat(ph);

  always_comb begin
    level_b_next = level_b;
    top_sc_next  = top_sc;
    new_sc       = scaled;
    wr_en        = 1'b0;
    if (adv) begin
      case (cmd.op)
        SC_SET, SC_COPY, SC_ZERO: begin
          if (cmd.op == SC_COPY) begin
            new_sc = top_sc;
          end else if (cmd.op == SC_ZERO) begin
            new_sc = '0;
          end
          wr_en        = 1'b1;
          top_sc_next  = new_sc;
          level_b_next = level_b + LEVEL_W'(1);
        end
        SC_POP: begin
          top_sc_next  = below_sc;
          level_b_next = level_b - LEVEL_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Prefetch the entry under the new top so a pop can use it next cycle
  assign rd_addr = level_b_next - LEVEL_W'(2);

  crs_ram #(
    .WIDTH($bits(scissor_t)),
    .DEPTH(STACK_DEPTH)
  ) u_sc_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(level_b),
    .wr_data(new_sc),
    .rd_addr(rd_addr),
    .rd_data(below_sc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level_b <= '0;
    end else begin
      level_b <= level_b_next;
    end
  end

  always_ff @(posedge clk) begin
    top_sc <= top_sc_next;
  end

  assign sc_out = top_sc_next;

  `CRS_IMPLIES(a_sc_pop_nonempty, adv && cmd.op == SC_POP, level_b != '0, "pop on empty stack")
  `CRS_IMPLIES(a_sc_push_room, wr_en, level_b != LEVEL_MAX, "push on full stack")

endmodule

`default_nettype wire

// ----- src/clip_rectangle_stack.sv -----
// Clip rectangle stack. Commands arrive on the s_ stream with the command code in
// s_tuser: push clip (intersect the rectangle with the top region and push), push
// no clip (push a full-window region), pop, classify a rectangle against the top
// region, and clip a rectangle to it. Up to STACK_DEPTH-1 regions are held; a push
// on a full stack or a pop on an empty one leaves the stack alone and reports
// overflow or underflow in m_tuser. Every command returns one result carrying the
// scissor window of the top region after the command, scaled by scale_q8/256 and
// truncated toward zero at push time. One command is accepted per clock while
// m_tready is high. An accepted command has its region stage (stack pointer,
// top-of-stack register and region memory) captured when it is accepted; its
// scissor stage (four Q8 multipliers and the scissor memory) is then captured in
// the result register once that register is free, and the result is offered from
// there. While a result waits, one more command is held in the region stage and
// then s_tready drops. Both memories need no clearing after reset, so commands are
// taken from the first cycle. Write configuration only while no command is in
// flight.
`default_nettype none

`include "clip_rectangle_stack_macros.svh"

module clip_rectangle_stack (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // rect_x, rect_y, rect_w, rect_h
  input  logic [crs_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd
  input  logic [crs_pkg::CMD_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // scissor_on, scissor_x, scissor_y, scissor_w, scissor_h, visibility,
  // box_x, box_y, box_w, box_h, box_changed, zero padding
  output logic [crs_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status
  output logic [crs_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import crs_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                scissor_on;
    logic [1:0]          visibility;
    logic signed [16:0]  box_x;
    logic signed [16:0]  box_y;
    logic signed [17:0]  box_w;
    logic signed [17:0]  box_h;
    logic                box_changed;
  } res_t;

  // Configuration
  logic [WIN_W-1:0]   window_width;
  logic [WIN_W-1:0]   window_height;
  logic [SCALE_W-1:0] scale_q8;

  // Handshake
  logic s_fire;
  logic a_valid;
  logic a_move;
  logic o_valid;
  logic o_free;
  logic ovf_push;

  // Region stack
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] level_upd;
  logic [LEVEL_W-1:0] rd_addr;
  region_t            top;
  region_t            top_next;
  region_t            below;
  region_t            new_reg;
  region_t            set_reg;
  logic               wr_en;
  logic               level_ne;

  // Input fields
  logic [CMD_W-1:0]   cmd;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_w;
  logic signed [15:0] in_h;

  // Edges and intersection
  logic signed [16:0] in_r;
  logic signed [16:0] in_b;
  logic signed [16:0] gx17;
  logic signed [16:0] gy17;
  logic signed [16:0] gr;
  logic signed [16:0] gb;
  logic signed [16:0] rr;
  logic signed [16:0] rb;
  logic signed [15:0] rx;
  logic signed [15:0] ry;
  logic signed [17:0] iw;
  logic signed [17:0] ih;

  // Region build
  logic               isect;
  logic signed [15:0] set_x;
  logic signed [15:0] set_y;
  logic signed [17:0] set_w;
  logic signed [17:0] set_h;
  logic signed [17:0] reg_w;
  logic signed [17:0] reg_h;
  logic signed [18:0] ww19;
  logic signed [18:0] wh19;
  logic               set_degen;
  logic               set_covers;
  logic [1:0]         set_kind;

  // Stage registers
  res_t               res_next;
  res_t               a_res;
  sc_cmd_t            sc_next;
  sc_cmd_t            a_sc;
  scissor_t           sc_out;
  scissor_t           sc_shown;
  logic [OUT_DATA_W-1:0] o_data;
  logic [STATUS_W-1:0]   o_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= RST_WINDOW_WIDTH;
      window_height <= RST_WINDOW_HEIGHT;
      scale_q8      <= RST_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_W-1:0];
        CFG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_W-1:0];
        CFG_SCALE:         scale_q8      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Two-slot pipeline: region stage register, then result register
  assign o_free   = !o_valid || m_tready;
  assign a_move   = a_valid && o_free;
  assign s_tready = !a_valid || o_free;
  assign s_fire   = s_tvalid && s_tready;

  assign cmd  = s_tuser;
  assign in_x = s_tdata[15:0];
  assign in_y = s_tdata[31:16];
  assign in_w = s_tdata[47:32];
  assign in_h = s_tdata[63:48];

  assign level_ne = (level != '0);

  assign in_r = 17'(in_x) + 17'(in_w);
  assign in_b = 17'(in_y) + 17'(in_h);
  assign gx17 = 17'(top.x);
  assign gy17 = 17'(top.y);
  assign gr   = 17'(top.x) + 17'(top.w);
  assign gb   = 17'(top.y) + 17'(top.h);
  assign rx   = (in_x > top.x) ? in_x : top.x;
  assign ry   = (in_y > top.y) ? in_y : top.y;
  assign rr   = (in_r < gr) ? in_r : gr;
  assign rb   = (in_b < gb) ? in_b : gb;
  assign iw   = 18'(rr) - 18'(rx);
  assign ih   = 18'(rb) - 18'(ry);

  // Region from a rectangle: empty when degenerate, full when it covers the window
  assign isect      = level_ne && (top.kind == KIND_RECT);
  assign set_x      = isect ? rx : in_x;
  assign set_y      = isect ? ry : in_y;
  assign set_w      = isect ? iw : 18'(in_w);
  assign set_h      = isect ? ih : 18'(in_h);
  assign set_degen  = (set_w <= 18'sd0) || (set_h <= 18'sd0);
  assign reg_w      = set_degen ? 18'sd1 : set_w;
  assign reg_h      = set_degen ? 18'sd1 : set_h;
  assign ww19       = $signed({4'd0, window_width});
  assign wh19       = $signed({4'd0, window_height});
  assign set_covers = (set_x <= 16'sd0) && (set_y <= 16'sd0) &&
                      (19'(set_x) + 19'(set_w) > ww19) &&
                      (19'(set_y) + 19'(set_h) >= wh19);
  assign set_kind   = set_covers ? KIND_FULL : (set_degen ? KIND_EMPTY : KIND_RECT);

  assign set_reg.kind = set_kind;
  assign set_reg.x    = set_x;
  assign set_reg.y    = set_y;
  assign set_reg.w    = reg_w[15:0];
  assign set_reg.h    = reg_h[15:0];

  always_comb begin
    level_next  = level;
    top_next    = top;
    new_reg     = set_reg;
    wr_en       = 1'b0;
    sc_next.op  = SC_NONE;
    sc_next.opx = 20'(set_x);
    sc_next.opy = 20'(wh19) - 20'(reg_h) - 20'(set_y) + 20'sd1;
    sc_next.opw = 20'(reg_w) - 20'sd1;
    sc_next.oph = 20'(reg_h) - 20'sd1;
    res_next             = '0;
    res_next.status      = ST_OK;
    res_next.visibility  = VIS_OUTSIDE;
    case (cmd)
      CMD_PUSH_CLIP, CMD_PUSH_FULL: begin
        if (level == LEVEL_MAX) begin
          res_next.status = ST_OVERFLOW;
        end else begin
          if (cmd == CMD_PUSH_FULL) begin
            new_reg      = '0;
            new_reg.kind = KIND_FULL;
            sc_next.op   = SC_ZERO;
          end else if (level_ne && top.kind == KIND_EMPTY) begin
            new_reg    = top;
            sc_next.op = SC_COPY;
          end else begin
            sc_next.op = SC_SET;
          end
          wr_en      = 1'b1;
          top_next   = new_reg;
          level_next = level + LEVEL_W'(1);
        end
      end
      CMD_POP: begin
        if (!level_ne) begin
          res_next.status = ST_UNDERFLOW;
        end else begin
          top_next   = below;
          level_next = level - LEVEL_W'(1);
          sc_next.op = SC_POP;
        end
      end
      CMD_CLASSIFY: begin
        res_next.visibility = VIS_INSIDE;
        if (level_ne && top.kind == KIND_EMPTY) begin
          res_next.visibility = VIS_OUTSIDE;
        end else if (isect) begin
          if (in_r <= gx17 || 17'(in_x) >= gr || in_b <= gy17 || 17'(in_y) >= gb) begin
            res_next.visibility = VIS_OUTSIDE;
          end else if (in_x >= top.x && in_y >= top.y && in_r <= gr && in_b <= gb) begin
            res_next.visibility = VIS_INSIDE;
          end else begin
            res_next.visibility = VIS_PARTIAL;
          end
        end
      end
      CMD_CLIP_BOX: begin
        if (level_ne && top.kind != KIND_FULL) begin
          res_next.box_x       = 17'(rx);
          res_next.box_y       = 17'(ry);
          res_next.box_w       = iw;
          res_next.box_h       = ih;
          res_next.box_changed = (rx != in_x) || (ry != in_y) ||
                                 (iw != 18'(in_w)) || (ih != 18'(in_h));
        end else begin
          res_next.box_x = 17'(in_x);
          res_next.box_y = 17'(in_y);
          res_next.box_w = 18'(in_w);
          res_next.box_h = 18'(in_h);
        end
      end
      default: ;
    endcase
    res_next.scissor_on = (level_next != '0) && (top_next.kind != KIND_FULL);
  end

  assign level_upd = s_fire ? level_next : level;
  // Prefetch the entry under the new top so a pop can use it next cycle
  assign rd_addr   = level_upd - LEVEL_W'(2);

  crs_ram #(
    .WIDTH($bits(region_t)),
    .DEPTH(STACK_DEPTH)
  ) u_region_ram (
    .clk    (clk),
    .wr_en  (wr_en && s_fire),
    .wr_addr(level),
    .wr_data(new_reg),
    .rd_addr(rd_addr),
    .rd_data(below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      level <= level_upd;
      if (s_fire) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      top   <= top_next;
      a_res <= res_next;
      a_sc  <= sc_next;
    end
  end

  crs_scissor u_scissor (
    .clk   (clk),
    .rst   (rst),
    .adv   (a_move),
    .cmd   (a_sc),
    .scale (scale_q8),
    .sc_out(sc_out)
  );

  assign sc_shown = a_res.scissor_on ? sc_out : '0;

  always_ff @(posedge clk) begin
    if (a_move) begin
      o_status <= a_res.status;
      o_data   <= {6'd0, a_res.box_changed, a_res.box_h, a_res.box_w,
                   a_res.box_y, a_res.box_x, a_res.visibility,
                   sc_shown.h, sc_shown.w, sc_shown.y, sc_shown.x,
                   a_res.scissor_on};
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;
  assign m_tuser  = o_status;

  assign ovf_push = s_fire && (cmd == CMD_PUSH_CLIP || cmd == CMD_PUSH_FULL) &&
                    (level == LEVEL_MAX);

  `CRS_NEXT(a_overflow_hold, ovf_push, level == LEVEL_MAX, "overflowing push changed the stack")
  `CRS_NEXT(a_idle_hold, !s_fire, $stable(level), "stack level moved without a transaction")
  `CRS_NEXT(a_slot_hold, a_valid && !o_free, a_valid, "stalled transaction dropped")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  import crs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST         = 3'd7;
  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } clip_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                on;
    logic signed [19:0]  sx;
    logic signed [19:0]  sy;
    logic signed [19:0]  sw;
    logic signed [19:0]  sh;
    logic [1:0]          vis;
    logic signed [16:0]  bx;
    logic signed [16:0]  by;
    logic signed [17:0]  bw;
    logic signed [17:0]  bh;
    logic                changed;
  } clip_result_t;

  typedef struct {
    logic [1:0] kind;
    int x, y, w, h;
    int sx, sy, sw, sh;
  } shadow_region_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic [CMD_W-1:0]        s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]     m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  clip_cmd_t      pending_cmds[$];
  clip_result_t   expected_results[$];

  // Shadow copy of the clip stack and its registers
  shadow_region_t shadow_stack[STACK_DEPTH];
  int depth_used = 0;
  int cfg_width  = int'(RST_WINDOW_WIDTH);
  int cfg_height = int'(RST_WINDOW_HEIGHT);
  int cfg_scale  = int'(RST_SCALE);

  int  send_gap_pct = 0;
  int  sink_stall_pct = 0;
  bit  sender_hold = 1'b0;
  int  error_count = 0;
  int  cycle_count = 0;

  clip_rectangle_stack dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int scaled(input int v);
    longint p;
    p = (longint'(v) * longint'(cfg_scale)) / 256;
    if (p > 524287) p = 524287;
    if (p < -524288) p = -524288;
    return int'(p);
  endfunction

  function automatic void store_region(input int i, input int x, input int y,
                                       input int w, input int h);
    shadow_region_t e;
    if (w <= 0 || h <= 0) begin
      e.kind = KIND_EMPTY;
      e.w = 1;
      e.h = 1;
    end else begin
      e.kind = KIND_RECT;
      e.w = w;
      e.h = h;
    end
    e.x = x;
    e.y = y;
    e.sx = scaled(e.x);
    e.sy = scaled(cfg_height - e.h - e.y + 1);
    e.sw = scaled(e.w - 1);
    e.sh = scaled(e.h - 1);
    // a rectangle covering the whole window turns the scissor off
    if (x <= 0 && y <= 0 && x + w > cfg_width && y + h >= cfg_height) e.kind = KIND_FULL;
    shadow_stack[i] = e;
  endfunction

  function automatic clip_result_t apply_command(input clip_cmd_t c);
    clip_result_t   res;
    shadow_region_t g;
    int x, y, w, h, r, b, gr, gb, bx, by, bw, bh;
    x = c.x;
    y = c.y;
    w = c.w;
    h = c.h;
    res = '{default: 0};
    if (depth_used != 0) g = shadow_stack[depth_used - 1];
    case (c.op)
      CMD_PUSH_CLIP, CMD_PUSH_FULL: begin
        if (depth_used >= STACK_DEPTH - 1) begin
          res.status = ST_OVERFLOW;
        end else if (c.op == CMD_PUSH_FULL) begin
          shadow_stack[depth_used] = '{kind: KIND_FULL, default: 0};
          depth_used++;
        end else begin
          if (depth_used == 0 || g.kind == KIND_FULL) begin
            store_region(depth_used, x, y, w, h);
          end else if (g.kind == KIND_EMPTY) begin
            shadow_stack[depth_used] = g;
          end else begin
            bx = (x > g.x) ? x : g.x;
            by = (y > g.y) ? y : g.y;
            r = (x + w < g.x + g.w) ? x + w : g.x + g.w;
            b = (y + h < g.y + g.h) ? y + h : g.y + g.h;
            store_region(depth_used, bx, by, r - bx, b - by);
          end
          depth_used++;
        end
      end
      CMD_POP: begin
        if (depth_used == 0) res.status = ST_UNDERFLOW;
        else depth_used--;
      end
      CMD_CLASSIFY: begin
        res.vis = VIS_INSIDE;
        if (depth_used != 0 && g.kind == KIND_EMPTY) begin
          res.vis = VIS_OUTSIDE;
        end else if (depth_used != 0 && g.kind == KIND_RECT) begin
          r = x + w;
          b = y + h;
          gr = g.x + g.w;
          gb = g.y + g.h;
          if (r <= g.x || x >= gr || b <= g.y || y >= gb) res.vis = VIS_OUTSIDE;
          else if (x >= g.x && y >= g.y && r <= gr && b <= gb) res.vis = VIS_INSIDE;
          else res.vis = VIS_PARTIAL;
        end
      end
      CMD_CLIP_BOX: begin
        bx = x;
        by = y;
        bw = w;
        bh = h;
        if (depth_used != 0 && g.kind != KIND_FULL) begin
          bx = (x > g.x) ? x : g.x;
          by = (y > g.y) ? y : g.y;
          bw = ((x + w < g.x + g.w) ? x + w : g.x + g.w) - bx;
          bh = ((y + h < g.y + g.h) ? y + h : g.y + g.h) - by;
          res.changed = (x != bx || y != by || w != bw || h != bh);
        end
        res.bx = bx;
        res.by = by;
        res.bw = bw;
        res.bh = bh;
      end
      default: ;
    endcase
    if (depth_used != 0 && shadow_stack[depth_used - 1].kind != KIND_FULL) begin
      g = shadow_stack[depth_used - 1];
      res.on = 1'b1;
      res.sx = g.sx;
      res.sy = g.sy;
      res.sw = g.sw;
      res.sh = g.sh;
    end
    return res;
  endfunction

  task automatic note_error(input string what, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Driver: present the oldest pending command, hold it until the handshake completes
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(apply_command(pending_cmds.pop_front()));
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && !sender_hold &&
            $urandom_range(99) >= send_gap_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {pending_cmds[0].h, pending_cmds[0].w, pending_cmds[0].y, pending_cmds[0].x};
          s_tuser  <= pending_cmds[0].op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin : monitor
    clip_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status  = m_tuser;
        got.on      = m_tdata[0];
        got.sx      = m_tdata[20:1];
        got.sy      = m_tdata[40:21];
        got.sw      = m_tdata[60:41];
        got.sh      = m_tdata[80:61];
        got.vis     = m_tdata[82:81];
        got.bx      = m_tdata[99:83];
        got.by      = m_tdata[116:100];
        got.bw      = m_tdata[134:117];
        got.bh      = m_tdata[152:135];
        got.changed = m_tdata[153];
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) $display("result with no command pending");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) note_error("status", want.status, got.status);
          if (got.on !== want.on) note_error("scissor_on", want.on, got.on);
          if (got.sx !== want.sx) note_error("scissor_x", want.sx, got.sx);
          if (got.sy !== want.sy) note_error("scissor_y", want.sy, got.sy);
          if (got.sw !== want.sw) note_error("scissor_w", want.sw, got.sw);
          if (got.sh !== want.sh) note_error("scissor_h", want.sh, got.sh);
          if (got.vis !== want.vis) note_error("visibility", want.vis, got.vis);
          if (got.bx !== want.bx) note_error("box_x", want.bx, got.bx);
          if (got.by !== want.by) note_error("box_y", want.by, got.by);
          if (got.bw !== want.bw) note_error("box_w", want.bw, got.bw);
          if (got.bh !== want.bh) note_error("box_h", want.bh, got.bh);
          if (got.changed !== want.changed) note_error("box_changed", want.changed, got.changed);
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_WINDOW_WIDTH:  cfg_width = value & 32'h7fff;
      CFG_WINDOW_HEIGHT: cfg_height = value & 32'h7fff;
      CFG_SCALE:         cfg_scale = value & 32'hfff;
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] op, input int x, input int y,
                         input int w, input int h);
    clip_cmd_t c;
    c.op = op;
    c.x = 16'(x);
    c.y = 16'(y);
    c.w = 16'(w);
    c.h = 16'(h);
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [15:0] pick_coord(input bit is_size);
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return 16'($urandom);
    if (is_size) return (roll < 25) ? 16'(-int'($urandom_range(0, 20))) : 16'($urandom_range(1, 700));
    return 16'(int'($urandom_range(0, 750)) - 50);
  endfunction

  // Random walk of the stack depth toward a goal that moves every 40 commands
  task automatic fill_random(input int count);
    clip_cmd_t c;
    int level_guess, goal, pick;
    level_guess = depth_used;
    goal = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) goal = $urandom_range(0, STACK_DEPTH + 1);
      pick = $urandom_range(99);
      c.x = pick_coord(1'b0);
      c.y = pick_coord(1'b0);
      c.w = pick_coord(1'b1);
      c.h = pick_coord(1'b1);
      if ($urandom_range(9) == 0) begin
        c.x = 16'(-int'($urandom_range(0, 100)));
        c.y = 16'(-int'($urandom_range(0, 100)));
        c.w = 16'(32767 - $urandom_range(0, 3));
        c.h = 16'(32767 - $urandom_range(0, 3));
      end
      if (pick < 5) begin
        c.op = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST));
      end else if (pick < 20) begin
        c.op = CMD_CLASSIFY;
      end else if (pick < 35) begin
        c.op = CMD_CLIP_BOX;
      end else if ((level_guess < goal) == ($urandom_range(3) != 0)) begin
        c.op = ($urandom_range(4) == 0) ? CMD_PUSH_FULL : CMD_PUSH_CLIP;
        if (level_guess < STACK_DEPTH - 1) level_guess++;
      end else begin
        c.op = CMD_POP;
        if (level_guess > 0) level_guess--;
      end
      pending_cmds.push_back(c);
    end
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    // two-stage pipeline, leave a little margin
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int width, input int height, input int scale,
                           input int gap, input int stall, input int count,
                           input bit squeeze);
    write_reg(CFG_WINDOW_WIDTH, width);
    write_reg(CFG_WINDOW_HEIGHT, height);
    write_reg(CFG_SCALE, scale);
    @(negedge clk);
    send_gap_pct = gap;
    sink_stall_pct = stall;
    fill_random(count);
    if (squeeze) begin
      while (pending_cmds.size() > count / 2) @(negedge clk);
      sender_hold = 1'b1;
      while (s_tvalid || expected_results.size() != 0) @(negedge clk);
      repeat (3) @(negedge clk);
      sender_hold = 1'b0;
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty stack
    add_cmd(CMD_POP, 0, 0, 0, 0);
    add_cmd(CMD_CLASSIFY, -32768, -32768, 32767, 32767);
    add_cmd(CMD_CLIP_BOX, 32767, 32767, -32768, -32768);
    // rectangle on top
    add_cmd(CMD_PUSH_CLIP, 10, 20, 100, 50);
    add_cmd(CMD_CLASSIFY, 20, 30, 10, 10);
    add_cmd(CMD_CLASSIFY, 500, 400, 10, 10);
    add_cmd(CMD_CLASSIFY, 0, 0, 50, 50);
    add_cmd(CMD_CLIP_BOX, 0, 0, 50, 50);
    add_cmd(CMD_CLIP_BOX, 20, 30, 10, 10);
    add_cmd(CMD_PUSH_CLIP, 50, 40, 200, 200);
    // disjoint push leaves an empty region, and pushes over it stay empty
    add_cmd(CMD_PUSH_CLIP, 400, 400, 10, 10);
    add_cmd(CMD_PUSH_CLIP, 0, 0, 1000, 1000);
    add_cmd(CMD_CLASSIFY, 60, 50, 5, 5);
    add_cmd(CMD_CLIP_BOX, 60, 50, 5, 5);
    // full region on top
    add_cmd(CMD_PUSH_FULL, 0, 0, 0, 0);
    add_cmd(CMD_CLASSIFY, -32768, 32767, 32767, -32768);
    add_cmd(CMD_CLIP_BOX, -32768, 32767, 32767, -32768);
    add_cmd(CMD_PUSH_CLIP, -5, -5, 700, 500);
    add_cmd(CMD_POP, 0, 0, 0, 0);
    add_cmd(CMD_PUSH_CLIP, 5, 5, 0, -3);
    add_cmd(CMD_FIRST_UNUSED, 1, 2, 3, 4);
    add_cmd(CMD_W'(6), -1, -1, -1, -1);
    add_cmd(CMD_LAST, 32767, -32768, 32767, -32768);
    add_cmd(CMD_POP, 0, 0, 0, 0);
    add_cmd(CMD_POP, 0, 0, 0, 0);
    drain();

    run_phase(640, 480, 256, 0, 0, 100, 1'b0);
    run_phase(32767, 32767, 2048, 55, 0, 100, 1'b0);
    run_phase(0, 0, 1, 0, 55, 100, 1'b0);
    run_phase(100, 80, 0, 13, 13, 100, 1'b0);
    run_phase(1000, 700, 4095, 0, 0, 100, 1'b1);
    run_phase($urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(1, 2048),
              13, 13, 100, 1'b0);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
